// ----- rtl/core/rsabd_pkg.sv -----
// ----------------------------------------------------------------------------
// rsabd_pkg: shared types and constants
// Field widths, register indexes and state encodings of the RSA block
// decryptor and its modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package rsabd_pkg;

	// Width of the ciphertext field and of the configuration data
	localparam int FIELD_W = 63;
	localparam int CFG_IDX_W = 1;
	localparam int BYTE_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

	// Top level sequencer
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REDUCE = 5'b00010,
		ST_SQUARE = 5'b00100,
		ST_MULT   = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	// Modular multiplier sequencer
	typedef enum logic [3:0] {
		MS_IDLE = 4'b0001,
		MS_PRE1 = 4'b0010,
		MS_PRE2 = 4'b0100,
		MS_RUN  = 4'b1000
	} mstate_t;

endpackage

`default_nettype wire

// ----- rtl/core/rsabd_mulmod.sv -----
// ----------------------------------------------------------------------------
// rsabd_mulmod: bit-serial modular multiplier
// Computes a*b mod m one multiplier bit per cycle, MSB first. Requires a < m.
// ----------------------------------------------------------------------------
`default_nettype none

module rsabd_mulmod #(
	parameter int W = 63
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic [W-1:0] m,
	output logic              done,
	output logic [W-1:0]      res
);
	import rsabd_pkg::*;

	localparam int CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

	mstate_t           state_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [W-1:0]      a_q;
	logic [W-1:0]      b_q;
	logic [W-1:0]      r_q;
	logic signed [W+1:0] am_q;   // a - m
	logic signed [W+1:0] a2m_q;  // a - 2m

	logic signed [W+1:0] mext, aext, t, s_dbl, s_a, s_am, s_a2m, nxt;

	always_comb begin
		mext  = $signed({2'b00, m});
		aext  = $signed({2'b00, a_q});
		t     = $signed({1'b0, r_q, 1'b0});
		s_dbl = t - mext;
		s_a   = t + aext;
		s_am  = t + am_q;
		s_a2m = t + a2m_q;
		// 2r + a stays below 3m: pick the one candidate in [0, m)
		if (b_q[W-1]) begin
			if (!s_a2m[W+1])
				nxt = s_a2m;
			else if (!s_am[W+1])
				nxt = s_am;
			else
				nxt = s_a;
		end else begin
			nxt = s_dbl[W+1] ? t : s_dbl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MS_IDLE: begin
					cnt_q <= '0;
					if (start)
						state_q <= MS_PRE1;
				end
				MS_PRE1: state_q <= MS_PRE2;
				MS_PRE2: state_q <= MS_RUN;
				MS_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						done_q  <= 1'b1;
						state_q <= MS_IDLE;
					end
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MS_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
					r_q <= '0;
				end
			end
			MS_PRE1: am_q  <= aext - mext;
			MS_PRE2: a2m_q <= am_q - mext;
			MS_RUN: begin
				r_q <= nxt[W-1:0];
				b_q <= {b_q[W-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

`default_nettype wire

// ----- rtl/core/rsa_block_decrypt_to_bytes.sv -----
// ----------------------------------------------------------------------------
// rsa_block_decrypt_to_bytes: RSA block decryption with byte output
// Modular exponentiation of one ciphertext block, then byte serialization.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write the private exponent (index REG_EXPONENT) and the
//   modulus (index REG_MODULUS) on the cfg channel while the block is idle.
//   cfg_ready is always high. Values are taken modulo 2^MOD_BITS.
//   Items: an item is accepted when start is high and busy is low. The
//   block computes cipher_block^d mod n and emits the plaintext bytes MSB
//   first, leading zero bytes dropped, last_byte set on the final byte.
//   A plaintext of zero, or a modulus below two, emits nothing.
//   Results: one byte per cycle with result_valid high for that cycle
//   only; the receiver cannot stall, so bytes come back to back.
// Schedule (W = MOD_BITS):
//   Every modular product runs in the bit-serial multiplier, the single
//   shared unit that sets the rate. One product reduces the block mod n,
//   then W squarings plus one product per set exponent bit, then byte
//   output. One item at a time: busy drops as the last byte is shown.
// Reset: asynchronous; exponent clears to 0, modulus to 1, block goes idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_block_decrypt_to_bytes #(
	parameter int MOD_BITS = 63
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// item channel
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [rsabd_pkg::FIELD_W-1:0]   cipher_block,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rsabd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rsabd_pkg::FIELD_W-1:0]   cfg_data,
	// result channel
	output logic                                 result_valid,
	output logic [rsabd_pkg::BYTE_W-1:0]         plain_byte,
	output logic                                 last_byte
);
	import rsabd_pkg::*;

	localparam int W      = MOD_BITS;
	localparam int NB     = (W + BYTE_W - 1) / BYTE_W;   // bytes in a residue
	localparam int PW     = NB * BYTE_W;
	localparam int BC_W   = $clog2(NB + 1);
	localparam int EC_W   = $clog2(W);
	localparam logic [EC_W-1:0] E_LAST = EC_W'(W - 1);

	// configuration
	logic [W-1:0] exp_cfg_q;
	logic [W-1:0] mod_cfg_q;

	// sequencer
	state_t          state_q;
	logic            pend_q;     // launch multiplier next cycle
	logic [EC_W-1:0] ecnt_q;     // exponent bit position
	logic [W-1:0]    e_sh_q;     // exponent, MSB shifted out first
	logic [W-1:0]    base_q;     // block reduced mod n
	logic [W-1:0]    acc_q;      // running power

	// byte output
	logic [PW-1:0]   pw_q;
	logic [BC_W-1:0] bcnt_q;
	logic            started_q;
	logic            result_valid_q;
	logic [BYTE_W-1:0] plain_byte_q;
	logic            last_byte_q;

	// multiplier
	logic         mul_start, mul_done;
	logic [W-1:0] mul_a, mul_b, mul_res;

	logic               accept, mod_ok, last_ebit, adv;
	logic [BYTE_W-1:0]  top_byte;
	logic               emit;

	assign accept    = start && (state_q == ST_IDLE);
	assign mod_ok    = (mod_cfg_q > W'(1));
	assign last_ebit = (ecnt_q == E_LAST);
	assign top_byte  = pw_q[PW-1 -: BYTE_W];
	assign emit      = started_q || (top_byte != '0);

	// advance to the next exponent bit once its products are done
	always_comb begin
		adv = 1'b0;
		if (mul_done) begin
			if (state_q == ST_MULT)
				adv = 1'b1;
			else if (state_q == ST_SQUARE && !e_sh_q[W-1])
				adv = 1'b1;
		end
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = acc_q;
		mul_b     = acc_q;
		case (state_q)
			ST_IDLE: begin
				// reduction: 1 * c mod n
				mul_start = accept && mod_ok;
				mul_a     = W'(1);
				mul_b     = cipher_block[W-1:0];
			end
			ST_SQUARE: mul_start = pend_q;
			ST_MULT: begin
				mul_start = pend_q;
				mul_b     = base_q;
			end
			default: ;
		endcase
	end

	rsabd_mulmod #(
		.W(W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (mod_cfg_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cfg_q <= '0;
			mod_cfg_q <= W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPONENT: exp_cfg_q <= cfg_data[W-1:0];
				REG_MODULUS:  mod_cfg_q <= cfg_data[W-1:0];
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pend_q         <= 1'b0;
			ecnt_q         <= '0;
			bcnt_q         <= '0;
			started_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			pend_q         <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && mod_ok)
						state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					if (mul_done) begin
						ecnt_q  <= '0;
						pend_q  <= 1'b1;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE, ST_MULT: begin
					if (mul_done) begin
						if (adv) begin
							ecnt_q <= ecnt_q + EC_W'(1);
							if (last_ebit) begin
								bcnt_q    <= BC_W'(NB);
								started_q <= 1'b0;
								state_q   <= ST_EMIT;
							end else begin
								pend_q  <= 1'b1;
								state_q <= ST_SQUARE;
							end
						end else begin
							pend_q  <= 1'b1;
							state_q <= ST_MULT;
						end
					end
				end
				ST_EMIT: begin
					result_valid_q <= emit;
					started_q      <= started_q || emit;
					bcnt_q         <= bcnt_q - BC_W'(1);
					if (bcnt_q == BC_W'(1))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept)
					e_sh_q <= exp_cfg_q;
			end
			ST_REDUCE: begin
				if (mul_done) begin
					base_q <= mul_res;
					acc_q  <= W'(1);
				end
			end
			ST_SQUARE, ST_MULT: begin
				if (mul_done) begin
					acc_q <= mul_res;
					if (adv) begin
						e_sh_q <= {e_sh_q[W-2:0], 1'b0};
						pw_q   <= PW'(mul_res);
					end
				end
			end
			ST_EMIT: begin
				plain_byte_q <= top_byte;
				last_byte_q  <= (bcnt_q == BC_W'(1));
				pw_q         <= pw_q << BYTE_W;
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign plain_byte   = plain_byte_q;
	assign last_byte    = last_byte_q;

endmodule

`default_nettype wire

// ----- rtl/core/rsabd_chk.sv -----
// ----------------------------------------------------------------------------
// rsabd_chk: port-level checks for the RSA block decryptor
// Watches the item and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsabd_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic result_valid,
	input wire logic last_byte
);

	// bytes of one block come out back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_byte |=> result_valid)
		else $error("byte burst broken before last byte");

	// a non-final byte belongs to a block still in progress
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_byte |-> busy)
		else $error("non-final byte while idle");

	// the final byte is shown once the block has gone idle
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_byte |-> !busy)
		else $error("final byte while still busy");

	// a newly accepted block has no byte ready in its first cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !result_valid)
		else $error("byte output right after accept");

	// busy only goes high after an item was offered
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a start");

endmodule

bind rsa_block_decrypt_to_bytes rsabd_chk u_rsabd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.last_byte    (last_byte)
);

`default_nettype wire
